/* src/tbk_pkg.sv */
package tbk_pkg;

  // Defaults for the top-level parameters.
  localparam int SLOTS_DEF     = 16;
  localparam int TICK_BITS_DEF = 32;

  // Queue depths between the parts of the block.
  localparam int CMDQ_DEPTH = 2;
  localparam int RESQ_DEPTH = 4;

  // A tick reports at most this many fires; all slots still update.
  localparam int MAX_FIRES  = 16;
  localparam int FIRE_CNT_W = $clog2(MAX_FIRES + 1);

  localparam int SLOT_W = 4;
  localparam int VAL_W  = 32;

  // Input opcodes.
  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_CREATE = 2'd0;
  localparam logic [1:0] KIND_FREE   = 2'd1;
  localparam logic [1:0] KIND_FIRE   = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SLOT  = 2'd1;
  localparam logic [1:0] ST_NOT_USED = 2'd2;

  typedef enum logic [1:0] {
    CMD_CREATE,
    CMD_FREE,
    CMD_TICK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [SLOT_W-1:0]  slot;
    logic [VAL_W-1:0]   delay;
    logic [VAL_W-1:0]   period;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [SLOT_W-1:0]  slot_index;
    logic [1:0]         status;
    logic               last;
  } result_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_TICK,
    BK_FLUSH
  } back_state_t;

endpackage

/* src/tbk_fifo.sv */
module tbk_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0] mem [DEPTH];
  logic [AW:0]  wp_r, wp_nxt;
  logic [AW:0]  rp_r, rp_nxt;

  // Pointers carry one extra bit so that full and empty differ.
  assign empty = (wp_r == rp_r);
  assign full  = (wp_r[AW] != rp_r[AW]) && (wp_r[AW-1:0] == rp_r[AW-1:0]);
  assign rdata = mem[rp_r[AW-1:0]];

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    if (push && !full) begin
      wp_nxt = wp_r + 1'b1;
    end
    if (pop && !empty) begin
      rp_nxt = rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wp_r[AW-1:0]] <= wdata;
    end
  end

endmodule

/* src/tbk_front.sv */
module tbk_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  logic [1:0]    in_opcode,
  input  logic [3:0]    in_slot,
  input  logic [31:0]   in_start_delay,
  input  logic [31:0]   in_period,
  input  logic          cmd_pop,
  output logic          cmd_empty,
  output tbk_pkg::cmd_t cmd_data
);

  import tbk_pkg::*;

  cmd_t cmd_in;
  logic keep;
  logic cmdq_full;

  // Unknown opcodes are taken and dropped here; they never reach the engine.
  always_comb begin
    cmd_in.slot   = in_slot;
    cmd_in.delay  = in_start_delay;
    cmd_in.period = in_period;
    cmd_in.kind   = CMD_TICK;
    keep          = 1'b1;
    unique case (in_opcode)
      OP_CREATE: cmd_in.kind = CMD_CREATE;
      OP_FREE:   cmd_in.kind = CMD_FREE;
      OP_TICK:   cmd_in.kind = CMD_TICK;
      default:   keep = 1'b0;
    endcase
  end

  assign in_full = cmdq_full;

  tbk_fifo #(
    .W     ($bits(cmd_t)),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push && keep),
    .wdata (cmd_in),
    .full  (cmdq_full),
    .pop   (cmd_pop),
    .rdata (cmd_data),
    .empty (cmd_empty)
  );

endmodule

/* src/tbk_back.sv */
module tbk_back #(
  parameter int SLOTS     = tbk_pkg::SLOTS_DEF,
  parameter int TICK_BITS = tbk_pkg::TICK_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_empty,
  input  tbk_pkg::cmd_t    cmd_data,
  output logic             cmd_pop,
  input  logic             res_full,
  output logic             res_push,
  output tbk_pkg::result_t res_data
);

  import tbk_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = (TICK_BITS > VAL_W) ? TICK_BITS : VAL_W;
  localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);

  logic [TICK_BITS-1:0] cnt_mem [SLOTS];
  logic [VAL_W-1:0]     dly_mem [SLOTS];
  logic [VAL_W-1:0]     per_mem [SLOTS];

  logic [TICK_BITS-1:0] cnt_rd_r;
  logic [VAL_W-1:0]     dly_rd_r;
  logic [VAL_W-1:0]     per_rd_r;

  back_state_t          state_r, state_nxt;
  logic [SW-1:0]        idx_r, idx_nxt;
  logic [SLOTS-1:0]     used_r, used_nxt;
  logic [SLOTS-1:0]     run_r, run_nxt;
  logic [FIRE_CNT_W-1:0] n_r, n_nxt;
  logic                 hold_v_r, hold_v_nxt;
  logic [SLOT_W-1:0]    hold_slot_r, hold_slot_nxt;

  logic                 free_found;
  logic [SW-1:0]        free_idx;
  logic [SW-1:0]        rel_idx;
  logic                 rel_in_range;

  logic [TICK_BITS-1:0] cnt_inc;
  logic [CW-1:0]        inc_w;
  logic [CW-1:0]        thr_w;
  logic [CW-1:0]        diff_w;
  logic                 fire;
  logic [TICK_BITS-1:0] cnt_new;

  logic                 new_we;
  logic                 cnt_we;
  logic [SW-1:0]        cnt_waddr;
  logic [TICK_BITS-1:0] cnt_wdata;

  // Lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  assign rel_idx      = SW'(cmd_data.slot);
  assign rel_in_range = (32'(cmd_data.slot) < 32'(SLOTS));

  // One slot update: saturating increment, then compare against the delay
  // while waiting or the period while running.
  always_comb begin
    cnt_inc = (&cnt_rd_r) ? cnt_rd_r : cnt_rd_r + 1'b1;
    inc_w   = CW'(cnt_inc);
    thr_w   = CW'(run_r[idx_r] ? per_rd_r : dly_rd_r);
    fire    = (inc_w >= thr_w);
    diff_w  = inc_w - thr_w;
    cnt_new = fire ? diff_w[TICK_BITS-1:0] : cnt_inc;
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    used_nxt      = used_r;
    run_nxt       = run_r;
    n_nxt         = n_r;
    hold_v_nxt    = hold_v_r;
    hold_slot_nxt = hold_slot_r;
    cmd_pop       = 1'b0;
    res_push      = 1'b0;
    res_data      = '0;
    new_we        = 1'b0;
    cnt_we        = 1'b0;

    unique case (state_r)
      BK_IDLE: begin
        idx_nxt = '0;
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          unique case (cmd_data.kind)
            CMD_CREATE: begin
              res_push      = 1'b1;
              res_data.kind = KIND_CREATE;
              res_data.last = 1'b1;
              if (free_found) begin
                used_nxt[free_idx]  = 1'b1;
                run_nxt[free_idx]   = 1'b0;
                new_we              = 1'b1;
                res_data.slot_index = SLOT_W'(free_idx);
                res_data.status     = ST_OK;
              end else begin
                res_data.slot_index = '0;
                res_data.status     = ST_NO_SLOT;
              end
            end
            CMD_FREE: begin
              res_push            = 1'b1;
              res_data.kind       = KIND_FREE;
              res_data.last       = 1'b1;
              res_data.slot_index = cmd_data.slot;
              if (rel_in_range && used_r[rel_idx]) begin
                used_nxt[rel_idx] = 1'b0;
                run_nxt[rel_idx]  = 1'b0;
                res_data.status   = ST_OK;
              end else begin
                res_data.status   = ST_NOT_USED;
              end
            end
            CMD_TICK: begin
              state_nxt  = BK_TICK;
              n_nxt      = '0;
              hold_v_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end

      BK_TICK: begin
        if (!res_full) begin
          if (used_r[idx_r]) begin
            cnt_we = 1'b1;
            if (fire) begin
              run_nxt[idx_r] = 1'b1;
              // The newest fire is held back until we know whether it is the last.
              if (n_r < FIRE_CNT_W'(MAX_FIRES)) begin
                if (hold_v_r) begin
                  res_push            = 1'b1;
                  res_data.kind       = KIND_FIRE;
                  res_data.slot_index = hold_slot_r;
                  res_data.status     = ST_OK;
                  res_data.last       = 1'b0;
                end
                hold_v_nxt    = 1'b1;
                hold_slot_nxt = SLOT_W'(idx_r);
                n_nxt         = n_r + 1'b1;
              end
            end
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = BK_FLUSH;
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      BK_FLUSH: begin
        idx_nxt = '0;
        if (!res_full) begin
          if (hold_v_r) begin
            res_push            = 1'b1;
            res_data.kind       = KIND_FIRE;
            res_data.slot_index = hold_slot_r;
            res_data.status     = ST_OK;
            res_data.last       = 1'b1;
          end
          hold_v_nxt = 1'b0;
          state_nxt  = BK_IDLE;
        end
      end

      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  assign cnt_waddr = new_we ? free_idx : idx_r;
  assign cnt_wdata = new_we ? '0 : cnt_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      idx_r    <= '0;
      used_r   <= '0;
      run_r    <= '0;
      n_r      <= '0;
      hold_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      used_r   <= used_nxt;
      run_r    <= run_nxt;
      n_r      <= n_nxt;
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_slot_r <= hold_slot_nxt;
  end

  // The read address runs one slot ahead of the slot being updated, so the
  // write of the current slot never meets the read of the same slot.
  always_ff @(posedge clk) begin
    if (new_we || cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rd_r <= cnt_mem[idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (new_we) begin
      dly_mem[free_idx] <= cmd_data.delay;
    end
    dly_rd_r <= dly_mem[idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (new_we) begin
      per_mem[free_idx] <= cmd_data.period;
    end
    per_rd_r <= per_mem[idx_nxt];
  end

endmodule

/* src/delayed_periodic_timer_bank_top.sv */
// Bank of periodic timer slots with a start delay.
// Input channel (in_push / in_full): one beat is a command. Opcode create
// claims the lowest free slot, free releases in_slot, tick advances every
// used slot by one. Beats with an unknown opcode are taken and dropped.
// Result channel (out_empty / out_pop): create and free each give one beat;
// a tick gives one fire beat per firing slot in ascending slot order, at most
// sixteen, and none when no slot fires. out_last marks a command's final beat.
// A create or free beat passes through the command queue, the idle engine and
// the result queue. Throughput: one create or free per cycle while the result
// queue has room; a tick occupies the engine as it walks the slot memory
// through a single read port, one slot per cycle while the queue has room.
// A two-entry command queue decouples the input from the engine, so commands
// keep being taken while the engine works on a tick.
// Reset (rst_n low, synchronous) frees every slot and empties both queues.
// When the receiver stalls, the result queue fills and the engine waits;
// the command queue then fills and in_full rises. No beat is lost.
module delayed_periodic_timer_bank_top #(
  parameter int SLOTS     = tbk_pkg::SLOTS_DEF,
  parameter int TICK_BITS = tbk_pkg::TICK_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_opcode,
  input  logic [3:0]  in_slot,
  input  logic [31:0] in_start_delay,
  input  logic [31:0] in_period,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_slot_index,
  output logic [1:0]  out_status,
  output logic        out_last
);

  import tbk_pkg::*;

  cmd_t    cmd_data;
  logic    cmd_empty;
  logic    cmd_pop;
  result_t res_in;
  result_t res_out;
  logic    res_push;
  logic    res_full;

  tbk_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_opcode      (in_opcode),
    .in_slot        (in_slot),
    .in_start_delay (in_start_delay),
    .in_period      (in_period),
    .cmd_pop        (cmd_pop),
    .cmd_empty      (cmd_empty),
    .cmd_data       (cmd_data)
  );

  tbk_back #(
    .SLOTS     (SLOTS),
    .TICK_BITS (TICK_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_data),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_in)
  );

  tbk_fifo #(
    .W     ($bits(result_t)),
    .DEPTH (RESQ_DEPTH)
  ) u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_out),
    .empty (out_empty)
  );

  assign out_kind       = res_out.kind;
  assign out_slot_index = res_out.slot_index;
  assign out_status     = res_out.status;
  assign out_last       = res_out.last;

endmodule

/* sim/delayed_periodic_timer_bank_top_test.sv */
`timescale 1ns / 100ps

module delayed_periodic_timer_bank_top_test;
  import tbk_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         ITEM_COUNT  = 155;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         DRAIN_WAIT  = 2 * SLOTS_DEF + 8;

  class timer_bank_scoreboard;
    logic        used [SLOTS_DEF];
    logic        running [SLOTS_DEF];
    logic [31:0] ticks [SLOTS_DEF];
    logic [31:0] delay_val [SLOTS_DEF];
    logic [31:0] period_val [SLOTS_DEF];
    result_t     awaited_answers [$];
    int          errors;

    function new();
      errors = 0;
      for (int i = 0; i < SLOTS_DEF; i++) begin
        used[i] = 1'b0;
        running[i] = 1'b0;
        ticks[i] = '0;
        delay_val[i] = '0;
        period_val[i] = '0;
      end
    endfunction

    function int pending();
      return awaited_answers.size();
    endfunction

    // Returns a random slot in use, or -1 when the bank is empty.
    function int pick_used();
      int idx [$];
      for (int i = 0; i < SLOTS_DEF; i++)
        if (used[i]) idx.push_back(i);
      if (idx.size() == 0) return -1;
      return idx[$urandom_range(0, idx.size() - 1)];
    endfunction

    function void push_answer(logic [1:0] kind, int idx, logic [1:0] status,
                              logic last);
      result_t r;
      r.kind = kind;
      r.slot_index = idx[SLOT_W-1:0];
      r.status = status;
      r.last = last;
      awaited_answers.push_back(r);
    endfunction

    // Updates the slot bank for one accepted command beat and queues the
    // answers it must produce.
    function void note_command(logic [1:0] op, logic [3:0] sl, logic [31:0] dly,
                               logic [31:0] per);
      int fired;
      int first_free;
      logic fire;
      fired = 0;
      first_free = -1;
      case (op)
        OP_CREATE: begin
          for (int i = SLOTS_DEF - 1; i >= 0; i--)
            if (!used[i]) first_free = i;
          if (first_free < 0) begin
            push_answer(KIND_CREATE, 0, ST_NO_SLOT, 1'b1);
          end else begin
            used[first_free] = 1'b1;
            running[first_free] = 1'b0;
            ticks[first_free] = '0;
            delay_val[first_free] = dly;
            period_val[first_free] = per;
            push_answer(KIND_CREATE, first_free, ST_OK, 1'b1);
          end
        end
        OP_FREE: begin
          if (used[sl]) begin
            used[sl] = 1'b0;
            running[sl] = 1'b0;
            push_answer(KIND_FREE, int'(sl), ST_OK, 1'b1);
          end else begin
            push_answer(KIND_FREE, int'(sl), ST_NOT_USED, 1'b1);
          end
        end
        OP_TICK: begin
          for (int i = 0; i < SLOTS_DEF; i++) begin
            if (used[i]) begin
              fire = 1'b0;
              if (ticks[i] != '1) ticks[i] = ticks[i] + 1;
              if (!running[i]) begin
                if (ticks[i] >= delay_val[i]) begin
                  running[i] = 1'b1;
                  ticks[i] = ticks[i] - delay_val[i];
                  fire = 1'b1;
                end
              end else if (ticks[i] >= period_val[i]) begin
                ticks[i] = ticks[i] - period_val[i];
                fire = 1'b1;
              end
              if (fire && fired < MAX_FIRES) begin
                push_answer(KIND_FIRE, i, ST_OK, 1'b0);
                fired++;
              end
            end
          end
          if (fired > 0) awaited_answers[$].last = 1'b1;
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(logic [1:0] kind, logic [3:0] idx, logic [1:0] status,
                               logic last);
      result_t exp_r;
      if (awaited_answers.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result beat: kind %0d slot %0d status %0d last %0d",
                   kind, idx, status, last);
        return;
      end
      exp_r = awaited_answers.pop_front();
      if (exp_r.kind !== kind || exp_r.slot_index !== idx ||
          exp_r.status !== status || exp_r.last !== last) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch (kind/slot/status/last): expected %0d/%0d/%0d/%0d",
                   exp_r.kind, exp_r.slot_index, exp_r.status, exp_r.last,
                   ", got %0d/%0d/%0d/%0d", kind, idx, status, last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [1:0]  in_opcode = OP_TICK;
  logic [3:0]  in_slot = '0;
  logic [31:0] in_start_delay = '0;
  logic [31:0] in_period = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [1:0]  out_kind;
  logic [3:0]  out_slot_index;
  logic [1:0]  out_status;
  logic        out_last;

  logic        no_idle = 1'b0;
  int          cycles = 0;

  timer_bank_scoreboard sb = new();

  delayed_periodic_timer_bank_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_opcode      (in_opcode),
    .in_slot        (in_slot),
    .in_start_delay (in_start_delay),
    .in_period      (in_period),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_kind       (out_kind),
    .out_slot_index (out_slot_index),
    .out_status     (out_status),
    .out_last       (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("delayed_periodic_timer_bank_top_test failed");
      $finish;
    end
  end

  // Result side: take a beat whenever one is offered and pop was high.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty)
      sb.check_result(out_kind, out_slot_index, out_status, out_last);
    out_pop <= no_idle || ($urandom_range(0, 99) >= 30);
  end

  task automatic send_cmd(input logic [1:0] op, input logic [3:0] sl,
                          input logic [31:0] dly, input logic [31:0] per);
    while (!no_idle && $urandom_range(0, 99) < 30) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_opcode <= op;
    in_slot <= sl;
    in_start_delay <= dly;
    in_period <= per;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_command(op, sl, dly, per);
  endtask

  function automatic logic [31:0] pick_interval();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 4);
    if (r < 82) return $urandom_range(5, 20);
    if (r < 94) return $urandom();
    return '1;
  endfunction

  initial begin
    int n_items;
    int r;
    int victim;
    logic [1:0] op;
    logic [3:0] sl;

    n_items = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty bank, unknown opcode, extreme intervals, full bank
    // and a tick on which every slot fires.
    send_cmd(OP_FREE, 4'd15, '0, '0);
    send_cmd(OP_TICK, 4'($urandom()), $urandom(), $urandom());
    send_cmd(OP_UNUSED, 4'($urandom()), $urandom(), $urandom());
    send_cmd(OP_CREATE, 4'($urandom()), 32'd0, 32'd0);
    send_cmd(OP_CREATE, 4'($urandom()), '1, '1);
    send_cmd(OP_CREATE, 4'($urandom()), 32'd1, 32'd2);
    send_cmd(OP_TICK, 4'($urandom()), $urandom(), $urandom());
    send_cmd(OP_FREE, 4'd1, '0, '0);
    repeat (14) send_cmd(OP_CREATE, 4'($urandom()), 32'd0, 32'd0);
    send_cmd(OP_CREATE, 4'($urandom()), 32'd3, 32'd3);
    repeat (2) send_cmd(OP_TICK, 4'($urandom()), $urandom(), $urandom());

    // Random part: ticks, the most common command, over a churning set of slots.
    while (n_items < ITEM_COUNT) begin
      no_idle <= (n_items >= 70 && n_items < 120);
      r = $urandom_range(0, 99);
      sl = 4'($urandom());
      if (r < 25) begin
        op = OP_CREATE;
      end else if (r < 47) begin
        op = OP_FREE;
        victim = sb.pick_used();
        if (victim >= 0 && $urandom_range(0, 99) < 80) sl = victim[3:0];
      end else if (r < 95) begin
        op = OP_TICK;
      end else begin
        op = OP_UNUSED;
      end
      if (op == OP_CREATE)
        send_cmd(op, sl, pick_interval(), pick_interval());
      else
        send_cmd(op, sl, $urandom(), $urandom());
      if (op != OP_UNUSED) n_items++;
    end

    in_push <= 1'b0;
    no_idle <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    // A quiet tick may still be walking the slots; give it time to misbehave.
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("delayed_periodic_timer_bank_top_test passed");
    end else begin
      $display("delayed_periodic_timer_bank_top_test failed");
    end
    $finish;
  end

endmodule
